FILE: rtl/core/sdspi_pkg.sv
// Package with shared types, codes and constants of the SD card SPI host.
`default_nettype none
package sdspi_pkg;
  localparam int BLOCK_BYTES = 512;
  localparam int IDLE_CLOCK_BYTES = 10;
  localparam int CNT_W = 10;

  typedef enum logic [1:0] {
    ACT_INIT = 2'd0,
    ACT_READ = 2'd1,
    ACT_XCHG = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    PH_IDLE, PH_CLK, PH_CMD, PH_POLL, PH_RDATA, PH_BUSY, PH_STUFF, PH_TOKEN,
    PH_DATA, PH_CRC
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_NODISK = 3'd1, ST_NOINIT = 3'd2, ST_PARERR = 3'd3,
    ST_ERROR = 3'd4
  } status_t;

  localparam logic [5:0] CMD0 = 6'd0;
  localparam logic [5:0] CMD1 = 6'd1;
  localparam logic [5:0] CMD8 = 6'd8;
  localparam logic [5:0] CMD12 = 6'd12;
  localparam logic [5:0] CMD16 = 6'd16;
  localparam logic [5:0] CMD18 = 6'd18;
  localparam logic [5:0] ACMD41 = 6'd41;
  localparam logic [5:0] CMD55 = 6'd55;
  localparam logic [5:0] CMD58 = 6'd58;

  typedef struct packed {
    logic       tx_request;
    logic [7:0] tx_byte;
    logic       cs_active;
    logic       data_valid;
    logic [7:0] data_byte;
    logic       block_end;
    logic       done_res;
    logic [2:0] status;
    logic       high_capacity;
  } result_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  drive;
    logic        card_present;
    logic [31:0] sector;
    logic [15:0] block_count;
    logic [7:0]  rx_byte;
  } item_t;
endpackage
`default_nettype wire

FILE: rtl/core/sd_spi_init_and_block_read.sv
// Top level of the SD card SPI-mode host sequencer.
//  channel | dir | tdata, lowest field first            | tuser, lowest field first
//  s_axis  | in  | drive, sector, block_count, rx_byte  | action, card_present
//  m_axis  | out | tx_byte, data_byte, status, zeros    | flags, see the port list
// One request is taken per cycle while the output buffer has space; its result is registered there.
// The step logic sits between the request port and a two-entry output buffer.
// Reset clears the phase and all sequencer state.
// A stalled result side blocks new requests once both buffer entries are full.
`default_nettype none
module sd_spi_init_and_block_read #(
  parameter int IdleClockBytes = sdspi_pkg::IDLE_CLOCK_BYTES
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [63:0] s_axis_tdata,   // drive, sector, block_count, rx_byte
  input  wire  [2:0]  s_axis_tuser,   // action, card_present
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [23:0] m_axis_tdata,   // tx_byte, data_byte, status, 0
  output logic [5:0]  m_axis_tuser    // tx_request, cs_active, data_valid,
                                      // block_end, done_res, high_capacity
);
  sdspi_pkg::item_t   item;
  sdspi_pkg::result_t res, outq;
  logic space, step;

  assign item.action = s_axis_tuser[1:0];
  assign item.card_present = s_axis_tuser[2];
  assign item.drive = s_axis_tdata[7:0];
  assign item.sector = s_axis_tdata[39:8];
  assign item.block_count = s_axis_tdata[55:40];
  assign item.rx_byte = s_axis_tdata[63:56];

  assign s_axis_tready = space;
  assign step = s_axis_tvalid && space;

  sdspi_seq #(.IdleClockBytes(IdleClockBytes)) u_seq (
    .clk(clk), .rst(rst), .step(step), .item(item), .res(res)
  );

  sdspi_outreg u_out (
    .clk(clk), .rst(rst), .push(step), .din(res), .space(space),
    .valid(m_axis_tvalid), .pop(m_axis_tready), .dout(outq)
  );

  assign m_axis_tdata = {5'd0, outq.status, outq.data_byte, outq.tx_byte};
  assign m_axis_tuser = {outq.high_capacity, outq.done_res, outq.block_end,
                         outq.data_valid, outq.cs_active, outq.tx_request};
endmodule
`default_nettype wire

FILE: rtl/core/sdspi_seq.sv
// Sequencer state and the combinational step for one request.
`default_nettype none
module sdspi_seq #(
  parameter int IdleClockBytes = sdspi_pkg::IDLE_CLOCK_BYTES
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   step,
  input  sdspi_pkg::item_t      item,
  output sdspi_pkg::result_t    res
);
  localparam int CW = sdspi_pkg::CNT_W;

  sdspi_pkg::phase_t phase, phase_next;
  logic [CW-1:0] byte_counter, byte_counter_next;
  logic [47:0] command_frame, command_frame_next;
  logic [31:0] response_word, response_word_next;
  logic [7:0] last_r1, last_r1_next;
  logic card_v2, card_v2_next, block_addressing, block_addressing_next;
  logic [15:0] blocks_left, blocks_left_next;

  // State registers, updated on each accepted request.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= sdspi_pkg::PH_IDLE;
      byte_counter <= '0;
      command_frame <= '0;
      response_word <= '0;
      last_r1 <= '0;
      card_v2 <= 1'b0;
      block_addressing <= 1'b0;
      blocks_left <= '0;
    end else if (step) begin
      phase <= phase_next;
      byte_counter <= byte_counter_next;
      command_frame <= command_frame_next;
      response_word <= response_word_next;
      last_r1 <= last_r1_next;
      card_v2 <= card_v2_next;
      block_addressing <= block_addressing_next;
      blocks_left <= blocks_left_next;
    end
  end

  // Next state and result of one step.
  always_comb begin
    logic [7:0] r;
    logic [5:0] bc_idx, nc_idx;
    logic [31:0] bc_arg;
    logic bc, fin, ask_en, dv, be, req, cs;
    logic [7:0] tx;
    logic [2:0] st;
    sdspi_pkg::phase_t ask_ph;
    logic [5:0] cmd;
    logic [7:0] crc;
    logic [47:0] frm;
    logic [2:0] fidx;
    phase_next = phase;
    byte_counter_next = byte_counter;
    command_frame_next = command_frame;
    response_word_next = response_word;
    last_r1_next = last_r1;
    card_v2_next = card_v2;
    block_addressing_next = block_addressing;
    blocks_left_next = blocks_left;
    bc = 1'b0; bc_idx = '0; bc_arg = '0; fin = 1'b0; st = sdspi_pkg::ST_OK;
    ask_en = 1'b0; ask_ph = sdspi_pkg::PH_IDLE; dv = 1'b0; be = 1'b0;
    req = 1'b0; cs = 1'b0; tx = 8'hFF;
    cmd = command_frame[45:40];
    r = last_r1;
    nc_idx = '0;
    fidx = '0;
    frm = '0;

    case (item.action)
      sdspi_pkg::ACT_INIT: begin
        if (item.drive != 8'd0 || !item.card_present) begin
          fin = 1'b1; st = sdspi_pkg::ST_NODISK;
        end else begin
          block_addressing_next = 1'b0;
          card_v2_next = 1'b0;
          byte_counter_next = CW'(1);
          phase_next = sdspi_pkg::PH_CLK;
          req = 1'b1;
        end
      end
      sdspi_pkg::ACT_READ: begin
        if (item.drive != 8'd0) begin
          fin = 1'b1; st = sdspi_pkg::ST_PARERR;
        end else begin
          blocks_left_next = item.block_count;
          bc = 1'b1; bc_idx = sdspi_pkg::CMD18;
          bc_arg = block_addressing ? item.sector : {item.sector[22:0], 9'd0};
        end
      end
      sdspi_pkg::ACT_XCHG: begin
        // The response dispatch is evaluated on a flag set below.
        logic respond;
        respond = 1'b0;
        unique case (phase)
          sdspi_pkg::PH_IDLE: ;
          sdspi_pkg::PH_CLK: begin
            if (byte_counter < CW'(IdleClockBytes)) begin
              byte_counter_next = byte_counter + CW'(1);
              req = 1'b1;
            end else begin
              bc = 1'b1; bc_idx = sdspi_pkg::CMD0;
            end
          end
          sdspi_pkg::PH_CMD: begin
            if (byte_counter < CW'(6)) begin
              fidx = byte_counter[2:0];
              frm = command_frame >> (6'd40 - {fidx, 3'd0});
              req = 1'b1; cs = 1'b1; tx = frm[7:0];
              byte_counter_next = byte_counter + CW'(1);
            end else begin
              ask_en = 1'b1;
              ask_ph = (cmd == sdspi_pkg::CMD12) ? sdspi_pkg::PH_STUFF
                                                  : sdspi_pkg::PH_POLL;
            end
          end
          sdspi_pkg::PH_STUFF: begin
            ask_en = 1'b1; ask_ph = sdspi_pkg::PH_POLL;
          end
          sdspi_pkg::PH_POLL: begin
            if (item.rx_byte[7]) begin
              ask_en = 1'b1; ask_ph = sdspi_pkg::PH_POLL;
            end else begin
              last_r1_next = item.rx_byte;
              r = item.rx_byte;
              if (cmd == sdspi_pkg::CMD8 || cmd == sdspi_pkg::CMD58) begin
                byte_counter_next = '0;
                response_word_next = '0;
                ask_en = 1'b1; ask_ph = sdspi_pkg::PH_RDATA;
              end else if (cmd == sdspi_pkg::CMD12) begin
                ask_en = 1'b1; ask_ph = sdspi_pkg::PH_BUSY;
              end else begin
                respond = 1'b1;
              end
            end
          end
          sdspi_pkg::PH_RDATA: begin
            response_word_next = {response_word[23:0], item.rx_byte};
            byte_counter_next = byte_counter + CW'(1);
            if (byte_counter_next >= CW'(4)) respond = 1'b1;
            else begin
              ask_en = 1'b1; ask_ph = sdspi_pkg::PH_RDATA;
            end
          end
          sdspi_pkg::PH_BUSY: begin
            if (item.rx_byte == 8'hFF) respond = 1'b1;
            else begin
              ask_en = 1'b1; ask_ph = sdspi_pkg::PH_BUSY;
            end
          end
          sdspi_pkg::PH_TOKEN: begin
            if (item.rx_byte == 8'hFF) begin
              ask_en = 1'b1; ask_ph = sdspi_pkg::PH_TOKEN;
            end else if (item.rx_byte != 8'hFE) begin
              fin = 1'b1; st = sdspi_pkg::ST_ERROR;
            end else begin
              byte_counter_next = '0;
              ask_en = 1'b1; ask_ph = sdspi_pkg::PH_DATA;
            end
          end
          sdspi_pkg::PH_DATA: begin
            req = 1'b1; cs = 1'b1; dv = 1'b1;
            if (byte_counter == CW'(sdspi_pkg::BLOCK_BYTES - 1)) begin
              byte_counter_next = '0;
              phase_next = sdspi_pkg::PH_CRC;
              be = 1'b1;
            end else begin
              byte_counter_next = byte_counter + CW'(1);
            end
          end
          sdspi_pkg::PH_CRC: begin
            byte_counter_next = byte_counter + CW'(1);
            if (byte_counter_next < CW'(2)) begin
              ask_en = 1'b1; ask_ph = sdspi_pkg::PH_CRC;
            end else begin
              blocks_left_next = blocks_left - 16'd1;
              if (blocks_left_next != 16'd0) begin
                ask_en = 1'b1; ask_ph = sdspi_pkg::PH_TOKEN;
              end else begin
                bc = 1'b1; bc_idx = sdspi_pkg::CMD12;
              end
            end
          end
          default: begin
            fin = 1'b1; st = sdspi_pkg::ST_ERROR;
          end
        endcase

        // Dispatch on the command that has just been answered.
        if (respond) begin
          case (cmd)
            sdspi_pkg::CMD0: begin
              bc = 1'b1;
              bc_idx = (r == 8'h01) ? sdspi_pkg::CMD8 : sdspi_pkg::CMD0;
              bc_arg = (r == 8'h01) ? 32'h0000_01AA : 32'd0;
            end
            sdspi_pkg::CMD8: begin
              if (r != 8'h01) begin
                card_v2_next = 1'b0; bc = 1'b1; bc_idx = sdspi_pkg::CMD55;
              end else if (response_word_next == 32'h0000_01AA) begin
                card_v2_next = 1'b1; bc = 1'b1; bc_idx = sdspi_pkg::CMD55;
              end else begin
                fin = 1'b1; st = sdspi_pkg::ST_NOINIT;
              end
            end
            sdspi_pkg::CMD55, sdspi_pkg::ACMD41: begin
              if (r == 8'h01) begin
                bc = 1'b1;
                if (cmd == sdspi_pkg::CMD55) begin
                  bc_idx = sdspi_pkg::ACMD41;
                  bc_arg = card_v2 ? 32'h4000_0000 : 32'd0;
                end else begin
                  bc_idx = sdspi_pkg::CMD55;
                end
              end else if (card_v2) begin
                if (r != 8'h00) begin
                  fin = 1'b1; st = sdspi_pkg::ST_NOINIT;
                end else begin
                  bc = 1'b1; bc_idx = sdspi_pkg::CMD58;
                end
              end else if (r != 8'h00) begin
                bc = 1'b1; bc_idx = sdspi_pkg::CMD1;
              end else if (block_addressing) begin
                fin = 1'b1;
              end else begin
                bc = 1'b1; bc_idx = sdspi_pkg::CMD16;
                bc_arg = 32'(sdspi_pkg::BLOCK_BYTES);
              end
            end
            sdspi_pkg::CMD58: begin
              if (r != 8'h00) begin
                fin = 1'b1; st = sdspi_pkg::ST_NOINIT;
              end else begin
                block_addressing_next = response_word_next[30];
                if (response_word_next[30]) fin = 1'b1;
                else begin
                  bc = 1'b1; bc_idx = sdspi_pkg::CMD16;
                  bc_arg = 32'(sdspi_pkg::BLOCK_BYTES);
                end
              end
            end
            sdspi_pkg::CMD1: begin
              if (r == 8'h01) begin
                bc = 1'b1; bc_idx = sdspi_pkg::CMD1;
              end else if (r != 8'h00) begin
                fin = 1'b1; st = sdspi_pkg::ST_NOINIT;
              end else if (block_addressing) begin
                fin = 1'b1;
              end else begin
                bc = 1'b1; bc_idx = sdspi_pkg::CMD16;
                bc_arg = 32'(sdspi_pkg::BLOCK_BYTES);
              end
            end
            sdspi_pkg::CMD16: begin
              fin = 1'b1;
              st = (r != 8'h00) ? sdspi_pkg::ST_NOINIT : sdspi_pkg::ST_OK;
            end
            sdspi_pkg::CMD18: begin
              if (r != 8'h00) begin
                fin = 1'b1;
                st = r[5] ? sdspi_pkg::ST_PARERR : sdspi_pkg::ST_ERROR;
              end else if (blocks_left == 16'd0) begin
                bc = 1'b1; bc_idx = sdspi_pkg::CMD12;
              end else begin
                ask_en = 1'b1; ask_ph = sdspi_pkg::PH_TOKEN;
              end
            end
            sdspi_pkg::CMD12: begin
              fin = 1'b1;
              st = (r != 8'h00) ? sdspi_pkg::ST_ERROR : sdspi_pkg::ST_OK;
            end
            default: begin
              fin = 1'b1; st = sdspi_pkg::ST_ERROR;
            end
          endcase
        end
      end
      default: ;
    endcase

    // Common endings: start a command, ask for a byte, or finish.
    crc = (bc_idx == sdspi_pkg::CMD0) ? 8'h95 :
          (bc_idx == sdspi_pkg::CMD8) ? 8'h87 : 8'h00;
    nc_idx = bc_idx;
    if (bc) begin
      command_frame_next = {2'b01, nc_idx, bc_arg, crc};
      byte_counter_next = CW'(1);
      phase_next = sdspi_pkg::PH_CMD;
      req = 1'b1; cs = 1'b1; tx = {2'b01, nc_idx};
    end
    if (ask_en) begin
      phase_next = ask_ph;
      req = 1'b1; cs = 1'b1; tx = 8'hFF;
    end
    if (fin) phase_next = sdspi_pkg::PH_IDLE;

    res.tx_request = req;
    res.tx_byte = req ? tx : 8'hFF;
    res.cs_active = req & cs;
    res.data_valid = dv;
    res.data_byte = dv ? item.rx_byte : 8'h00;
    res.block_end = dv & be;
    res.done_res = fin;
    res.status = fin ? st : sdspi_pkg::ST_OK;
    res.high_capacity = block_addressing_next;
  end
endmodule
`default_nettype wire

FILE: rtl/core/sdspi_outreg.sv
// Two-entry output buffer that parts the result side from the request side.
`default_nettype none
module sdspi_outreg (
  input  wire                clk,
  input  wire                rst,
  input  wire                push,
  input  sdspi_pkg::result_t din,
  output logic               space,
  output logic               valid,
  input  wire                pop,
  output sdspi_pkg::result_t dout
);
  sdspi_pkg::result_t main_q, skid_q;
  logic main_v, skid_v;

  assign space = !skid_v;
  assign valid = main_v;
  assign dout = main_q;

  // Main register feeds the port; the skid entry catches a push under stall.
  always_ff @(posedge clk) begin
    if (rst) begin
      main_v <= 1'b0;
      skid_v <= 1'b0;
    end else begin
      if (!main_v || pop) begin
        main_v <= skid_v || push;
        skid_v <= 1'b0;
      end else if (push) begin
        skid_v <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!main_v || pop) main_q <= skid_v ? skid_q : din;
    if (push && main_v && !pop) skid_q <= din;
  end
endmodule
`default_nettype wire

FILE: rtl/core/sdspi_checker.sv
// Port-level checker for the SD card SPI host, bound to the top level.
`default_nettype none
module sdspi_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_axis_tvalid,
  input wire        s_axis_tready,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [23:0] m_axis_tdata,
  input wire [5:0]  m_axis_tuser
);
  // A result follows every request.
  a_follow: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("no result after request");
  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed under stall");
  // Status is zero unless done.
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[4] |-> m_axis_tdata[18:16] == 3'd0)
    else $error("status without done");
  // No byte request while finishing.
  a_done: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[4] |-> !m_axis_tuser[0])
    else $error("request on done");
endmodule

bind sd_spi_init_and_block_read sdspi_checker u_chk (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
  .m_axis_tuser(m_axis_tuser)
);
`default_nettype wire

FILE: sim/tb_top.sv
// Self-checking testbench for the SD card SPI-mode host sequencer.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sdspi_pkg::*;

  localparam int ITEMS = 1450;

  // Predicts each result from the requests and compares the block against it.
  class sd_host_tracker;
    phase_t      phase;
    int          cnt;
    logic [47:0] frame;
    logic [31:0] resp;
    logic [7:0]  r1;
    bit          v2;
    bit          blk;
    logic [15:0] left;
    result_t     pending_results[$];
    int          errors;
    int          n_results;
    int          n_done;
    int          n_blocks;

    function new();
      phase = PH_IDLE;
      cnt = 0;
      frame = '0;
      resp = '0;
      r1 = '0;
      v2 = 0;
      blk = 0;
      left = '0;
      errors = 0;
      n_results = 0;
      n_done = 0;
      n_blocks = 0;
    endfunction

    function logic [5:0] cur_cmd();
      return frame[45:40];
    endfunction

    function result_t emit(bit req, logic [7:0] tx, bit cs, bit dv, logic [7:0] db,
                           bit be, bit done, logic [2:0] st);
      result_t r;
      r.tx_request = req;
      r.tx_byte = req ? tx : 8'hFF;
      r.cs_active = req ? cs : 1'b0;
      r.data_valid = dv;
      r.data_byte = dv ? db : 8'h00;
      r.block_end = dv ? be : 1'b0;
      r.done_res = done;
      r.status = done ? st : 3'd0;
      r.high_capacity = blk;
      return r;
    endfunction

    function result_t finish_op(status_t st);
      phase = PH_IDLE;
      return emit(0, 8'hFF, 0, 0, 0, 0, 1, st);
    endfunction

    function result_t start_cmd(logic [5:0] idx, logic [31:0] arg);
      logic [7:0] crc;
      crc = (idx == CMD0) ? 8'h95 : (idx == CMD8) ? 8'h87 : 8'h00;
      frame = {2'b01, idx, arg, crc};
      cnt = 1;
      phase = PH_CMD;
      return emit(1, frame[47:40], 1, 0, 0, 0, 0, 0);
    endfunction

    function result_t wait_byte(phase_t next);
      phase = next;
      return emit(1, 8'hFF, 1, 0, 0, 0, 0, 0);
    endfunction

    function result_t init_tail();
      if (blk) return finish_op(ST_OK);
      return start_cmd(CMD16, BLOCK_BYTES);
    endfunction

    function result_t after_acmd(logic [7:0] r);
      if (v2) begin
        if (r != 8'h00) return finish_op(ST_NOINIT);
        return start_cmd(CMD58, 32'h0);
      end
      if (r != 8'h00) return start_cmd(CMD1, 32'h0);
      return init_tail();
    endfunction

    // Decision taken once the full response of a command has arrived.
    function result_t on_answer();
      logic [7:0] r;
      r = r1;
      case (cur_cmd())
        CMD0: begin
          if (r == 8'h01) return start_cmd(CMD8, 32'h000001AA);
          return start_cmd(CMD0, 32'h0);
        end
        CMD8: begin
          if (r != 8'h01) begin
            v2 = 0;
            return start_cmd(CMD55, 32'h0);
          end
          if (resp == 32'h000001AA) begin
            v2 = 1;
            return start_cmd(CMD55, 32'h0);
          end
          return finish_op(ST_NOINIT);
        end
        CMD55: begin
          if (r == 8'h01) return start_cmd(ACMD41, v2 ? 32'h40000000 : 32'h0);
          return after_acmd(r);
        end
        ACMD41: begin
          if (r == 8'h01) return start_cmd(CMD55, 32'h0);
          return after_acmd(r);
        end
        CMD58: begin
          if (r != 8'h00) return finish_op(ST_NOINIT);
          blk = resp[30];
          return init_tail();
        end
        CMD1: begin
          if (r == 8'h01) return start_cmd(CMD1, 32'h0);
          if (r != 8'h00) return finish_op(ST_NOINIT);
          return init_tail();
        end
        CMD16: return finish_op(r != 8'h00 ? ST_NOINIT : ST_OK);
        CMD18: begin
          if (r != 8'h00) return finish_op(r[5] ? ST_PARERR : ST_ERROR);
          if (left == 16'd0) return start_cmd(CMD12, 32'h0);
          return wait_byte(PH_TOKEN);
        end
        CMD12: return finish_op(r != 8'h00 ? ST_ERROR : ST_OK);
        default: return finish_op(ST_ERROR);
      endcase
    endfunction

    function result_t step(item_t it);
      logic [7:0] rx;
      rx = it.rx_byte;
      if (it.action == ACT_INIT) begin
        if (it.drive != 8'd0 || !it.card_present) return finish_op(ST_NODISK);
        blk = 0;
        v2 = 0;
        cnt = 1;
        phase = PH_CLK;
        return emit(1, 8'hFF, 0, 0, 0, 0, 0, 0);
      end
      if (it.action == ACT_READ) begin
        if (it.drive != 8'd0) return finish_op(ST_PARERR);
        left = it.block_count;
        return start_cmd(CMD18, blk ? it.sector : {it.sector[22:0], 9'd0});
      end
      if (it.action == ACT_NONE || phase == PH_IDLE) return emit(0, 8'hFF, 0, 0, 0, 0, 0, 0);
      case (phase)
        PH_CLK: begin
          if (cnt < IDLE_CLOCK_BYTES) begin
            cnt++;
            return emit(1, 8'hFF, 0, 0, 0, 0, 0, 0);
          end
          return start_cmd(CMD0, 32'h0);
        end
        PH_CMD: begin
          if (cnt < 6) begin
            cnt++;
            return emit(1, 8'(frame >> (40 - 8 * (cnt - 1))), 1, 0, 0, 0, 0, 0);
          end
          return wait_byte(cur_cmd() == CMD12 ? PH_STUFF : PH_POLL);
        end
        PH_STUFF: return wait_byte(PH_POLL);
        PH_POLL: begin
          if (rx[7]) return wait_byte(PH_POLL);
          r1 = rx;
          if (cur_cmd() == CMD8 || cur_cmd() == CMD58) begin
            cnt = 0;
            resp = '0;
            return wait_byte(PH_RDATA);
          end
          if (cur_cmd() == CMD12) return wait_byte(PH_BUSY);
          return on_answer();
        end
        PH_RDATA: begin
          resp = {resp[23:0], rx};
          cnt++;
          if (cnt >= 4) return on_answer();
          return wait_byte(PH_RDATA);
        end
        PH_BUSY: begin
          if (rx == 8'hFF) return on_answer();
          return wait_byte(PH_BUSY);
        end
        PH_TOKEN: begin
          if (rx == 8'hFF) return wait_byte(PH_TOKEN);
          if (rx != 8'hFE) return finish_op(ST_ERROR);
          cnt = 0;
          return wait_byte(PH_DATA);
        end
        PH_DATA: begin
          cnt++;
          if (cnt >= BLOCK_BYTES) begin
            cnt = 0;
            phase = PH_CRC;
            return emit(1, 8'hFF, 1, 1, rx, 1, 0, 0);
          end
          return emit(1, 8'hFF, 1, 1, rx, 0, 0, 0);
        end
        PH_CRC: begin
          cnt++;
          if (cnt < 2) return wait_byte(PH_CRC);
          left = left - 16'd1;
          if (left != 16'd0) return wait_byte(PH_TOKEN);
          return start_cmd(CMD12, 32'h0);
        end
        default: return finish_op(ST_ERROR);
      endcase
    endfunction

    function void note_request(item_t it);
      pending_results.push_back(step(it));
    endfunction

    function void cmp(string nm, int e, int a);
      if (e != a) begin
        $error("%s: expected 0x%0h, got 0x%0h", nm, e, a);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t e;
      if (pending_results.size() == 0) begin
        $error("result arrived with nothing expected");
        errors++;
        return;
      end
      e = pending_results.pop_front();
      n_results++;
      if (got.done_res) n_done++;
      if (got.block_end) n_blocks++;
      cmp("tx_request", e.tx_request, got.tx_request);
      cmp("tx_byte", e.tx_byte, got.tx_byte);
      cmp("cs_active", e.cs_active, got.cs_active);
      cmp("data_valid", e.data_valid, got.data_valid);
      cmp("data_byte", e.data_byte, got.data_byte);
      cmp("block_end", e.block_end, got.block_end);
      cmp("done_res", e.done_res, got.done_res);
      cmp("status", e.status, got.status);
      cmp("high_capacity", e.high_capacity, got.high_capacity);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic [5:0]  m_axis_tuser;

  sd_host_tracker tracker;
  int          n_sent;
  int          burst_left;
  bit          card_is_v2;
  int          stall_mode;
  int          stall_cycles;
  int          n_inits;
  int          n_reads;

  sd_spi_init_and_block_read u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on the run length.
  initial begin
    #10ms;
    $display("tb_top failed");
    $finish;
  end

  // Result side: stalls follow a randomly chosen mode: always ready, mostly ready or mostly stalled.
  initial begin
    m_axis_tready = 1'b0;
    stall_mode = 0;
    stall_cycles = 0;
    forever begin
      @(negedge clk);
      if (++stall_cycles >= 300) begin
        stall_cycles = 0;
        stall_mode = $urandom_range(0, 2);
      end
      case (stall_mode)
        0: m_axis_tready = 1'b1;
        1: m_axis_tready = ($urandom_range(0, 3) != 0);
        default: m_axis_tready = ($urandom_range(0, 9) < 3);
      endcase
    end
  end

  // Compare every accepted result with the oldest prediction.
  always @(posedge clk) begin
    result_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.tx_request = m_axis_tuser[0];
      got.cs_active = m_axis_tuser[1];
      got.data_valid = m_axis_tuser[2];
      got.block_end = m_axis_tuser[3];
      got.done_res = m_axis_tuser[4];
      got.high_capacity = m_axis_tuser[5];
      got.tx_byte = m_axis_tdata[7:0];
      got.data_byte = m_axis_tdata[15:8];
      got.status = m_axis_tdata[18:16];
      tracker.check_result(got);
    end
  end

  // Offer one request and hold it until taken; gaps fall between bursts.
  task automatic send_item(input item_t it);
    @(negedge clk);
    s_axis_tdata = {it.rx_byte, it.block_count, it.sector, it.drive};
    s_axis_tuser = {it.card_present, it.action};
    s_axis_tvalid = 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    tracker.note_request(it);
    n_sent++;
    if (--burst_left <= 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        repeat ($urandom_range(0, 5)) @(negedge clk);
      end
    end
  endtask

  task automatic send_fields(input logic [1:0] act, input logic [7:0] drv, input bit present,
                             input logic [31:0] sec, input logic [15:0] count,
                             input logic [7:0] rx);
    item_t it;
    it.action = act;
    it.drive = drv;
    it.card_present = present;
    it.sector = sec;
    it.block_count = count;
    it.rx_byte = rx;
    send_item(it);
  endtask

  task automatic drain();
    while (tracker.pending_results.size() != 0) @(posedge clk);
  endtask

  // Card side: answer the byte the sequencer is waiting for, mostly as a real card would.
  function automatic logic [7:0] card_answer();
    logic [5:0] c;
    c = tracker.cur_cmd();
    case (tracker.phase)
      PH_POLL: begin
        if ($urandom_range(0, 3) == 0) return 8'h80 | 8'($urandom);
        case (c)
          CMD0: return ($urandom_range(0, 9) != 0) ? 8'h01 : 8'h00;
          CMD8: return card_is_v2 ? 8'h01 : 8'h05;
          CMD55: return ($urandom_range(0, 9) != 0) ? 8'h01 : 8'h05;
          ACMD41: begin
            if (!card_is_v2 && $urandom_range(0, 3) == 0) return 8'h05;
            return $urandom_range(0, 1) ? 8'h01 : 8'h00;
          end
          CMD1: return $urandom_range(0, 1) ? 8'h01 : 8'h00;
          CMD18: begin
            if ($urandom_range(0, 9) != 0) return 8'h00;
            return $urandom_range(0, 1) ? 8'h20 : 8'h04;
          end
          default: return ($urandom_range(0, 9) != 0) ? 8'h00 : 8'h04;
        endcase
      end
      PH_RDATA: begin
        if (c == CMD8 && $urandom_range(0, 19) != 0) return 8'(32'h000001AA >> (8 * (3 - tracker.cnt)));
        return 8'($urandom);
      end
      PH_BUSY: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      PH_TOKEN: begin
        if ($urandom_range(0, 19) == 0) return 8'($urandom);
        return $urandom_range(0, 1) ? 8'hFF : 8'hFE;
      end
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    int r;
    tracker = new();
    n_sent = 0;
    n_inits = 0;
    n_reads = 0;
    burst_left = 8;
    card_is_v2 = 1;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: rejected starts, ignored items, read before init, abort of a read.
    send_fields(ACT_XCHG, 8'h00, 1, 32'h0, 16'h0, 8'hFF);
    send_fields(ACT_INIT, 8'hFF, 1, 32'h0, 16'h0, 8'h00);
    send_fields(ACT_INIT, 8'h00, 0, 32'h0, 16'h0, 8'h00);
    send_fields(ACT_READ, 8'h01, 1, 32'hFFFFFFFF, 16'hFFFF, 8'h00);
    send_fields(ACT_NONE, 8'hFF, 1, 32'hFFFFFFFF, 16'hFFFF, 8'hFF);
    send_fields(ACT_READ, 8'h00, 0, 32'hFFFFFFFF, 16'h0, 8'h00);
    repeat (8) send_fields(ACT_XCHG, 8'h00, 0, 32'h0, 16'h0, card_answer());
    send_fields(ACT_READ, 8'h00, 1, 32'h00800001, 16'hFFFF, 8'h00);
    repeat (8) send_fields(ACT_XCHG, 8'h00, 1, 32'h0, 16'h0, 8'h00);
    send_fields(ACT_NONE, 8'h00, 0, 32'h0, 16'h0, 8'h00);
    send_fields(ACT_INIT, 8'h00, 1, 32'h0, 16'h0, 8'h00);
    send_fields(ACT_INIT, 8'h80, 0, 32'h0, 16'h0, 8'h00);

    // Hold off until the block has caught up.
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    drain();

    // Random: mostly well-formed card sessions, some noise and aborted reads.
    while (n_sent < ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        send_fields(2'($urandom), 8'($urandom), 1'($urandom), $urandom, 16'($urandom),
                    8'($urandom));
      end else if (tracker.phase == PH_IDLE) begin
        if (n_inits == 0 || r < 45) begin
          card_is_v2 = ($urandom_range(0, 3) != 0);
          n_inits++;
          send_fields(ACT_INIT, 8'h00, 1, $urandom, 16'($urandom), 8'($urandom));
        end else begin
          n_reads++;
          send_fields(ACT_READ, 8'h00, 1'($urandom), $urandom,
                      ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 1)) : 16'($urandom),
                      8'($urandom));
        end
      end else if (tracker.phase == PH_DATA && tracker.left > 16'd1 &&
                   $urandom_range(0, 60) == 0) begin
        card_is_v2 = 1;
        n_inits++;
        send_fields(ACT_INIT, 8'h00, 1, $urandom, 16'($urandom), 8'($urandom));
      end else begin
        send_fields(ACT_XCHG, 8'($urandom), 1'($urandom), $urandom, 16'($urandom),
                    card_answer());
      end
    end

    @(negedge clk);
    s_axis_tvalid = 1'b0;
    drain();
    repeat (20) @(posedge clk);

    $display("Sent %0d requests (%0d init and %0d read starts); checked %0d results,",
             n_sent, n_inits, n_reads, tracker.n_results);
    $display("of which %0d finished an operation and %0d closed a data block.",
             tracker.n_done, tracker.n_blocks);
    if (tracker.errors == 0 && tracker.pending_results.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
